FILE: rtl/core/tfm_pkg.sv
// shared constants and types for the typed fifo mailbox
// no dependencies; imported by tfm_scan and typed_fifo_mailbox
`default_nettype none

package tfm_pkg;

    // default number of slots, at most SLOTS-1 items are held
    localparam int SLOTS_DEF = 16;

    // field widths
    localparam int TYPE_W    = 16;
    localparam int PAYLOAD_W = 64;
    localparam int OCC_W     = 4;
    localparam int STATUS_W  = 2;

    // stream data widths: fields packed from bit 0, padded to whole bytes
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    // operation codes carried on the input tuser
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    // result status codes carried on the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_SENT     = 2'd0,
        ST_RECEIVED = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tfm_scan.sv
// oldest-match tracker for the mailbox receive scan
// depends on tfm_pkg; fed one slot per cycle from the type/rank memory
`default_nettype none

module tfm_scan
    import tfm_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              chk_valid,
    input  wire logic [IDX_W-1:0]  chk_idx,
    input  wire logic [IDX_W-1:0]  last_idx,
    input  wire logic [TYPE_W-1:0] req_type,
    input  wire logic [TYPE_W-1:0] rd_type,
    input  wire logic [IDX_W-1:0]  rd_rank,
    output logic                   found,
    output logic [IDX_W-1:0]       pick,
    output logic [IDX_W-1:0]       best_rank,
    output logic [TYPE_W-1:0]      last_type,
    output logic [IDX_W-1:0]       last_rank
);

    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  pick_reg;
    logic [IDX_W-1:0]  best_rank_reg;
    logic [TYPE_W-1:0] last_type_reg;
    logic [IDX_W-1:0]  last_rank_reg;
    logic              hit;
    logic              at_last;

    // lower rank means earlier arrival
    assign hit = chk_valid && (rd_type == req_type)
                 && (!found_reg || (rd_rank < best_rank_reg));
    assign at_last = chk_valid && (chk_idx == last_idx);

    always_comb
    begin
        found_next = found_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (hit)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            pick_reg      <= chk_idx;
            best_rank_reg <= rd_rank;
        end
        if (at_last)
        begin
            last_type_reg <= rd_type;
            last_rank_reg <= rd_rank;
        end
    end

    assign found     = found_reg;
    assign pick      = pick_reg;
    assign best_rank = best_rank_reg;
    assign last_type = last_type_reg;
    assign last_rank = last_rank_reg;

endmodule

`default_nettype wire

FILE: rtl/core/typed_fifo_mailbox.sv
// typed fifo mailbox: top level with slot memories, sequencer and output register
// depends on tfm_pkg and tfm_scan
`default_nettype none

// A mailbox of SLOTS slots holding up to SLOTS-1 items, each a 16-bit type and
// a 64-bit payload. An input item with tuser 0 sends: it is stored behind the
// held ones, or refused with status full. An input item with tuser 1 receives:
// the oldest held item of the named type is returned and removed, the last held
// item moves into its slot and younger arrival ranks drop by one; with no match
// the status is empty and nothing changes. Every input item gives exactly one
// result item carrying status, payload (zero unless received) and the number of
// held items afterwards (low 4 bits). Items are handled one at a time. A send,
// or a receive on an empty mailbox, goes from acceptance straight to the done
// state. A receive with n items held scans all n slots and, after a match,
// repairs ranks: the type/rank memory has one read port, so the search reads one
// slot per cycle, and the rank repair after a match reads and writes back slots
// 0 to n-2 one per cycle. A result waiting in the output register blocks only
// the next result, not the next acceptance once the block is back in idle. No
// clearing pass is needed after reset.
module typed_fifo_mailbox
    import tfm_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // msg_type [15:0], payload [79:16]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // operation [0]
    input  wire logic                s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // payload_out [63:0], occupancy [67:64], zero pad [71:68]
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]      m_axis_tuser
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int TM_W  = TYPE_W + IDX_W;
    localparam int PAD_W = M_DATA_W - PAYLOAD_W - OCC_W;
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(SLOTS - 1);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_SCAN_END = 7'b0000100,
        S_FETCH    = 7'b0001000,
        S_ADJ      = 7'b0010000,
        S_DRAIN    = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    // what the payload memory read of last cycle was for
    typedef enum logic [1:0] {
        PT_NONE = 2'd0,
        PT_LAST = 2'd1,
        PT_PICK = 2'd2
    } ptag_t;

    // slot memories: {rank, type} and payload, one write and one read port each
    logic [TM_W-1:0]      tm_mem [SLOTS];
    logic [PAYLOAD_W-1:0] pl_mem [SLOTS];
    logic [TM_W-1:0]      tm_rd_reg;
    logic [PAYLOAD_W-1:0] pl_rd_reg;

    logic                 tm_we;
    logic [IDX_W-1:0]     tm_waddr;
    logic [TM_W-1:0]      tm_wdata;
    logic                 pl_we;
    logic [IDX_W-1:0]     pl_waddr;
    logic [PAYLOAD_W-1:0] pl_wdata;
    logic [IDX_W-1:0]     pl_raddr;

    // control registers
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] held_reg, held_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             wb_valid_reg, wb_valid_next;
    ptag_t            ptag_reg, ptag_next;
    logic             m_valid_reg, m_valid_next;

    // item registers
    logic [TYPE_W-1:0]    type_reg, type_next;
    status_t              status_reg, status_next;
    logic [PAYLOAD_W-1:0] data_reg, data_next;
    logic [PAYLOAD_W-1:0] last_pl_reg, last_pl_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]     wb_idx_reg, wb_idx_next;
    status_t              st_out_reg, st_out_next;
    logic [PAYLOAD_W-1:0] pl_out_reg, pl_out_next;
    logic [OCC_W-1:0]     occ_out_reg, occ_out_next;

    // scan results
    logic              scan_clear;
    logic              found;
    logic [IDX_W-1:0]  pick;
    logic [IDX_W-1:0]  best_rank;
    logic [TYPE_W-1:0] last_type;
    logic [IDX_W-1:0]  last_rank;

    logic                 accept;
    logic                 in_op;
    logic [TYPE_W-1:0]    in_type;
    logic [PAYLOAD_W-1:0] in_payload;
    logic [TYPE_W-1:0]    rd_type;
    logic [IDX_W-1:0]     rd_rank;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     moved_rank;

    assign in_op      = s_axis_tuser;
    assign in_type    = s_axis_tdata[TYPE_W-1:0];
    assign in_payload = s_axis_tdata[TYPE_W +: PAYLOAD_W];

    // one item in flight at a time; results wait in the output register
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rd_type  = tm_rd_reg[TYPE_W-1:0];
    assign rd_rank  = tm_rd_reg[TYPE_W +: IDX_W];
    assign last_idx = held_reg - 1'b1;

    // the entry moved into the freed slot keeps its order among the rest
    assign moved_rank = (last_rank > best_rank) ? (last_rank - 1'b1) : last_rank;

    tfm_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .chk_valid (chk_valid_reg),
        .chk_idx   (chk_idx_reg),
        .last_idx  (last_idx),
        .req_type  (type_reg),
        .rd_type   (rd_type),
        .rd_rank   (rd_rank),
        .found     (found),
        .pick      (pick),
        .best_rank (best_rank),
        .last_type (last_type),
        .last_rank (last_rank)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = idx_reg;
        wb_valid_next  = 1'b0;
        wb_idx_next    = idx_reg;
        ptag_next      = PT_NONE;
        type_next      = type_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        last_pl_next   = last_pl_reg;
        st_out_next    = st_out_reg;
        pl_out_next    = pl_out_reg;
        occ_out_next   = occ_out_reg;
        scan_clear     = 1'b0;
        pl_raddr       = pick;

        m_valid_next = m_valid_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        // payload memory read data lands in the cycle after the address
        case (ptag_reg)
            PT_LAST: last_pl_next = pl_rd_reg;
            PT_PICK: data_next    = pl_rd_reg;
            default: ;
        endcase

        // rank repair writeback, each slot written in the cycle after its read
        tm_we    = 1'b0;
        tm_waddr = wb_idx_reg;
        tm_wdata = tm_rd_reg;
        pl_we    = 1'b0;
        pl_waddr = pick;
        pl_wdata = last_pl_reg;
        if (wb_valid_reg)
        begin
            if (wb_idx_reg == pick)
            begin
                tm_we    = 1'b1;
                tm_waddr = pick;
                tm_wdata = {moved_rank, last_type};
                pl_we    = 1'b1;
            end
            else if (rd_rank > best_rank)
            begin
                tm_we    = 1'b1;
                tm_wdata = {rd_rank - 1'b1, rd_type};
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next = in_type;
                    data_next = '0;
                    if (in_op == OP_SEND)
                    begin
                        if (held_reg == FULL_COUNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // new item goes just past the held ones, youngest rank
                            tm_we       = 1'b1;
                            tm_waddr    = held_reg;
                            tm_wdata    = {held_reg + 1'b1, in_type};
                            pl_we       = 1'b1;
                            pl_waddr    = held_reg;
                            pl_wdata    = in_payload;
                            held_next   = held_reg + 1'b1;
                            status_next = ST_SENT;
                        end
                        state_next = S_DONE;
                    end
                    else if (held_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        scan_clear = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                // fetch the last held payload while the search runs
                if (idx_reg == '0)
                begin
                    pl_raddr  = last_idx;
                    ptag_next = PT_LAST;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (!found)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_RECEIVED;
                    pl_raddr    = pick;
                    ptag_next   = PT_PICK;
                    idx_next    = '0;
                    state_next  = (last_idx == '0) ? S_DRAIN : S_ADJ;
                end
            end
            S_ADJ:
            begin
                wb_valid_next = 1'b1;
                wb_idx_next   = idx_reg;
                if (idx_reg == IDX_W'(last_idx - 1'b1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    if (status_reg == ST_RECEIVED)
                    begin
                        held_next = held_reg - 1'b1;
                    end
                    m_valid_next = 1'b1;
                    st_out_next  = status_reg;
                    pl_out_next  = data_reg;
                    occ_out_next = OCC_W'(held_next);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            held_reg      <= '0;
            chk_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            ptag_reg      <= PT_NONE;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            held_reg      <= held_next;
            chk_valid_reg <= chk_valid_next;
            wb_valid_reg  <= wb_valid_next;
            ptag_reg      <= ptag_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
        last_pl_reg <= last_pl_next;
        chk_idx_reg <= chk_idx_next;
        wb_idx_reg  <= wb_idx_next;
        st_out_reg  <= st_out_next;
        pl_out_reg  <= pl_out_next;
        occ_out_reg <= occ_out_next;
    end

    // type/rank memory, read address is the sweep counter
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            tm_mem[tm_waddr] <= tm_wdata;
        end
        tm_rd_reg <= tm_mem[idx_reg];
    end

    // payload memory
    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            pl_mem[pl_waddr] <= pl_wdata;
        end
        pl_rd_reg <= pl_mem[pl_raddr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = st_out_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, occ_out_reg, pl_out_reg};

    // never more than SLOTS-1 items held
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= FULL_COUNT)
        else $error("held count beyond capacity");

    // a send write never meets a rank repair write
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_SEND)) |-> !wb_valid_reg)
        else $error("send write overlaps repair writeback");

    // held count moves only on a send acceptance or when a result is issued
    a_held_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(held_reg) |-> ($past(state_reg) == S_DONE) || $past(accept))
        else $error("held count changed outside send or result");

    // a result appears only out of the done state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_DONE))
        else $error("result issued outside done state");

    // a matched entry always carries a real rank
    a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FETCH) && found) |-> (best_rank != '0))
        else $error("matched entry has rank zero");

endmodule

`default_nettype wire
